// File: rtl/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types, constants and helper functions of the register log event
// extractor.
// ----------------------------------------------------------------------------
package rle_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 32;

    localparam logic [CfgIndexWidth-1:0] CfgDeviceKind    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgChannelSelect = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgSyncNumerator = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgSyncDenom     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgStartOffset   = 3'd4;

    localparam logic [7:0]  ChannelAll     = 8'hff;
    localparam logic [31:0] NumeratorReset = 32'd10;
    localparam logic [31:0] DenomReset     = 32'd1000;
    localparam logic [9:0]  Kilo           = 10'd1000;
    localparam int          TimeWidthDefault = 32;

    localparam logic [7:0] CmdPort0 = 8'h00;
    localparam logic [7:0] CmdPort1 = 8'h01;
    localparam logic [7:0] CmdTick  = 8'hff;
    localparam logic [7:0] CmdWait  = 8'hfe;
    localparam logic [7:0] CmdEnd   = 8'hfd;

    localparam logic [5:0] WaitShiftMax = 6'd35;
    localparam logic [5:0] WaitShiftLim = 6'd32;
    localparam logic [5:0] WaitStep     = 6'd7;

    typedef enum logic [1:0] {
        STATUS_WRITE = 2'd0,
        STATUS_END   = 2'd1,
        STATUS_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] offset;
        logic        port;
        logic [7:0]  addr;
        logic [7:0]  value;
    } event_t;

    typedef struct packed {
        logic       port;
        logic [7:0] addr_a;
        logic [7:0] addr_b;
    } chan_entry_t;

    localparam int OpnaChannels = 9;
    localparam int OpmChannels  = 8;

    localparam chan_entry_t OpnaChan [OpnaChannels] = '{
        '{1'b0, 8'ha0, 8'ha4}, '{1'b0, 8'ha1, 8'ha5}, '{1'b0, 8'ha2, 8'ha6},
        '{1'b1, 8'ha0, 8'ha4}, '{1'b1, 8'ha1, 8'ha5}, '{1'b1, 8'ha2, 8'ha6},
        '{1'b0, 8'h00, 8'h01}, '{1'b0, 8'h02, 8'h03}, '{1'b0, 8'h04, 8'h05}
    };

    function automatic logic is_note_reg(input logic opm, input logic [7:0] a);
        logic r;
        if (opm)
            r = (a >= 8'h28) && (a <= 8'h37);
        else
            r = (a <= 8'h06) || ((a >= 8'ha0) && (a <= 8'hae) && (a[1:0] != 2'b11));
        return r;
    endfunction

    function automatic logic chan_match(input logic opm, input logic [7:0] c,
                                        input logic p, input logic [7:0] a);
        logic        r;
        chan_entry_t e;
        e = OpnaChan[0];
        if (c == ChannelAll)
            r = 1'b1;
        else if (opm)
            r = (c < 8'(OpmChannels)) && !p
                && ((a == 8'h28 + c) || (a == 8'h30 + c));
        else if (c < 8'(OpnaChannels))
        begin
            e = OpnaChan[c[3:0]];
            r = (p == e.port) && ((a == e.addr_a) || (a == e.addr_b));
        end
        else
            r = 1'b0;
        return r;
    endfunction

    // One restoring divide step: {quotient bit, new remainder}.
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic dbit,
                                             input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] r;
        t = {rem, dbit};
        if (t >= {1'b0, den})
            r = {1'b1, 32'(t - {1'b0, den})};
        else
            r = {1'b0, t[31:0]};
        return r;
    endfunction

endpackage

// File: rtl/register_log_event_extractor.sv
// ----------------------------------------------------------------------------
// register_log_event_extractor
// Parses a sound-chip register dump byte stream and reports note register
// writes, end of dump and unknown commands with offset and time in ms.
//
// Input: s_tdata carries one dump byte per word. Output: one word per event,
// kind in m_tuser. Configuration goes through cfg_we/cfg_addr/cfg_data; the
// user must write it only while the block is idle, as the block does not
// enforce it. Writing start_offset reloads the byte position. A byte that
// causes an event is accepted, the time unit multiplies (32x32, then times
// 1000) and runs the two-bit-per-cycle divider, and the push state loads
// the output register. s_tready is low while the time unit runs. A finished
// word waits in the output register for m_tready; the next byte is accepted
// meanwhile, and a new event waits in the push state until the output
// register frees up. After end of dump or an unknown command all bytes are
// accepted and dropped until reset. Reset restores register defaults, clears
// the parser and empties the output.
// ----------------------------------------------------------------------------
module register_log_event_extractor #(
    parameter int TIME_WIDTH = rle_pkg::TimeWidthDefault
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // dump_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // event_offset[31:0], time_ms[63:32], port[64], reg_addr[72:65],
    // reg_value[80:73], zero[87:81]
    output logic [87:0]                        m_tdata,
    output logic [1:0]                         m_tuser,   // status
    input  logic                               cfg_we,
    input  logic [rle_pkg::CfgIndexWidth-1:0]  cfg_addr,
    input  logic [rle_pkg::CfgDataWidth-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic            kind_reg;
    logic [7:0]      chan_reg;
    logic [31:0]     num_reg;
    logic [31:0]     den_reg;
    rle_pkg::event_t pend_reg;
    rle_pkg::event_t out_reg;
    logic [31:0]     otime_reg;
    logic            ovalid_reg, ovalid_next;

    logic            accept;
    logic            evt_valid;
    rle_pkg::event_t evt;
    logic [31:0]     ticks;
    logic            t_busy;
    logic            t_done;
    logic [31:0]     t_time;
    logic [31:0]     num_eff;
    logic [31:0]     den_eff;
    logic            push;
    logic            pos_load;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign pos_load = cfg_we && (cfg_addr == rle_pkg::CfgStartOffset);
    assign num_eff  = (num_reg == 32'd0) ? rle_pkg::NumeratorReset : num_reg;
    assign den_eff  = (den_reg == 32'd0) ? rle_pkg::DenomReset : den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= 1'b0;
            chan_reg <= rle_pkg::ChannelAll;
            num_reg  <= rle_pkg::NumeratorReset;
            den_reg  <= rle_pkg::DenomReset;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                rle_pkg::CfgDeviceKind:    kind_reg <= cfg_data[0];
                rle_pkg::CfgChannelSelect: chan_reg <= cfg_data[7:0];
                rle_pkg::CfgSyncNumerator: num_reg  <= cfg_data[31:0];
                rle_pkg::CfgSyncDenom:     den_reg  <= cfg_data[31:0];
                default:                   ;
            endcase
        end
    end

    rle_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .byte_in        (s_tdata),
        .device_kind    (kind_reg),
        .channel_select (chan_reg),
        .pos_load       (pos_load),
        .pos_value      (cfg_data[31:0]),
        .evt_valid      (evt_valid),
        .evt            (evt),
        .ticks          (ticks)
    );

    rle_time #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_time (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && evt_valid),
        .ticks   (ticks),
        .num     (num_eff),
        .den     (den_eff),
        .busy    (t_busy),
        .done    (t_done),
        .time_ms (t_time)
    );

    assign push = (state_reg == ST_PUSH) && (!ovalid_reg || m_tready);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
                if (accept && evt_valid)
                    state_next = ST_CALC;
            ST_CALC:
                if (t_done)
                    state_next = ST_PUSH;
            ST_PUSH:
                if (push)
                begin
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && evt_valid)
            pend_reg <= evt;
        if (push)
        begin
            out_reg   <= pend_reg;
            otime_reg <= t_time;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'd0, out_reg.value, out_reg.addr, out_reg.port, otime_reg,
                       out_reg.offset};

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !t_busy)
        else $error("input ready while time unit busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && evt_valid) |=> (state_reg == ST_CALC && t_busy))
        else $error("event did not start time unit");

    assert property (@(posedge clk) disable iff (!rst_n)
        t_done |-> (state_reg == ST_CALC))
        else $error("time result outside calc state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !m_tready) |=> (ovalid_reg && $stable(otime_reg)))
        else $error("stalled output word changed");

endmodule

// File: rtl/rle_parser.sv
// ----------------------------------------------------------------------------
// rle_parser
// Byte stream parser: command decode, tick counting, variable-length waits
// and note register filtering.
// ----------------------------------------------------------------------------
module rle_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         byte_in,
    input  logic               device_kind,
    input  logic [7:0]         channel_select,
    input  logic               pos_load,
    input  logic [31:0]        pos_value,
    output logic               evt_valid,
    output rle_pkg::event_t    evt,
    output logic [31:0]        ticks
);

    typedef enum logic [4:0] {
        PH_CMD   = 5'b00001,
        PH_ADDR  = 5'b00010,
        PH_VALUE = 5'b00100,
        PH_WAIT  = 5'b01000,
        PH_HALT  = 5'b10000
    } phase_t;

    phase_t      phase_reg,  phase_next;
    logic [31:0] pos_reg,    pos_next;
    logic [31:0] tick_reg,   tick_next;
    logic        lport_reg,  lport_next;
    logic [7:0]  laddr_reg,  laddr_next;
    logic [31:0] cpos_reg,   cpos_next;
    logic [31:0] acc_reg,    acc_next;
    logic [5:0]  shift_reg,  shift_next;
    logic [31:0] wait_bits;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tick_next  = tick_reg;
        lport_next = lport_reg;
        laddr_next = laddr_reg;
        cpos_next  = cpos_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        evt_valid  = 1'b0;
        evt        = '{status: rle_pkg::STATUS_WRITE, offset: pos_reg, port: 1'b0,
                       addr: 8'd0, value: 8'd0};
        wait_bits  = 32'({32'd0, byte_in[6:0]} << shift_reg);

        if (accept && phase_reg != PH_HALT)
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_CMD:
                begin
                    if (byte_in == rle_pkg::CmdPort0 || byte_in == rle_pkg::CmdPort1)
                    begin
                        lport_next = byte_in[0];
                        cpos_next  = pos_reg;
                        phase_next = PH_ADDR;
                    end
                    else if (byte_in == rle_pkg::CmdTick)
                        tick_next = tick_reg + 32'd1;
                    else if (byte_in == rle_pkg::CmdWait)
                    begin
                        acc_next   = 32'd0;
                        shift_next = 6'd0;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        evt_valid  = 1'b1;
                        evt.status = (byte_in == rle_pkg::CmdEnd) ? rle_pkg::STATUS_END
                                                                 : rle_pkg::STATUS_ERROR;
                        phase_next = PH_HALT;
                    end
                end
                PH_ADDR:
                begin
                    laddr_next = byte_in;
                    phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    if (rle_pkg::is_note_reg(device_kind, laddr_reg)
                        && rle_pkg::chan_match(device_kind, channel_select,
                                               lport_reg, laddr_reg))
                    begin
                        evt_valid  = 1'b1;
                        evt.offset = cpos_reg;
                        evt.port   = lport_reg;
                        evt.addr   = laddr_reg;
                        evt.value  = byte_in;
                    end
                    phase_next = PH_CMD;
                end
                PH_WAIT:
                begin
                    if (shift_reg < rle_pkg::WaitShiftLim)
                        acc_next = acc_reg | wait_bits;
                    shift_next = (shift_reg + rle_pkg::WaitStep > rle_pkg::WaitShiftMax)
                                 ? rle_pkg::WaitShiftMax : shift_reg + rle_pkg::WaitStep;
                    if (!byte_in[7])
                    begin
                        tick_next  = tick_reg + acc_next + 32'd2;
                        phase_next = PH_CMD;
                    end
                end
                default:
                    phase_next = PH_HALT;
            endcase
        end

        if (pos_load)
            pos_next = pos_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            pos_reg   <= 32'd0;
            tick_reg  <= 32'd0;
            lport_reg <= 1'b0;
            laddr_reg <= 8'd0;
            cpos_reg  <= 32'd0;
            acc_reg   <= 32'd0;
            shift_reg <= 6'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            tick_reg  <= tick_next;
            lport_reg <= lport_next;
            laddr_reg <= laddr_next;
            cpos_reg  <= cpos_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
        end
    end

    assign ticks = tick_reg;

endmodule

// File: rtl/rle_time.sv
// ----------------------------------------------------------------------------
// rle_time
// Event time unit: ticks*num*1000 by the multiply states T_MUL and T_SCALE,
// then a restoring divider by den, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rle_time #(
    parameter int TIME_WIDTH = rle_pkg::TimeWidthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] ticks,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic        done,
    output logic [31:0] time_ms
);

    localparam int DvdWidth  = 64;
    localparam int DivSteps  = DvdWidth / 2;
    localparam int CntWidth  = $clog2(DivSteps);
    localparam int OutWidth  = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;

    typedef enum logic [3:0] {
        T_IDLE  = 4'b0001,
        T_MUL   = 4'b0010,
        T_SCALE = 4'b0100,
        T_DIV   = 4'b1000
    } tstate_t;

    tstate_t                 state_reg, state_next;
    logic [31:0]             tick_reg,  tick_next;
    logic [DvdWidth-1:0]     dvd_reg,   dvd_next;
    logic [31:0]             rem_reg,   rem_next;
    logic [TIME_WIDTH-1:0]   q_reg,     q_next;
    logic [CntWidth-1:0]     cnt_reg,   cnt_next;
    logic                    done_reg,  done_next;
    logic [32:0]             s1, s2;

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        s1 = rle_pkg::div_step(rem_reg, dvd_reg[DvdWidth-1], den);
        s2 = rle_pkg::div_step(s1[31:0], dvd_reg[DvdWidth-2], den);

        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    tick_next  = ticks;
                    state_next = T_MUL;
                end
            end
            T_MUL:
            begin
                dvd_next   = DvdWidth'(tick_reg) * DvdWidth'(num);
                state_next = T_SCALE;
            end
            T_SCALE:
            begin
                dvd_next   = dvd_reg * DvdWidth'(rle_pkg::Kilo);
                rem_next   = 32'd0;
                q_next     = '0;
                cnt_next   = CntWidth'(DivSteps - 1);
                state_next = T_DIV;
            end
            T_DIV:
            begin
                rem_next = s2[31:0];
                dvd_next = {dvd_reg[DvdWidth-3:0], 2'b00};
                q_next   = {q_reg[TIME_WIDTH-3:0], s1[32], s2[32]};
                cnt_next = cnt_reg - CntWidth'(1);
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
    end

    assign busy    = (state_reg != T_IDLE);
    assign done    = done_reg;
    assign time_ms = 32'(q_reg[OutWidth-1:0]);

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for register_log_event_extractor. Feeds one register
// dump as a byte stream: a directed script first, then phases of random
// write, tick and wait commands under changing register settings, and ends
// the dump with an end or unknown command byte. A local parser model
// predicts every event word, which is compared field by field with the
// output stream under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TimeWidth    = 32;
    localparam int RandomItems  = 1420;
    localparam int TailItems    = 150;
    localparam int IdleLatency  = 48;
    localparam int CycleLimit   = 400000;

    typedef enum logic [2:0] {
        SEEK_CMD,
        TAKE_ADDR,
        TAKE_VALUE,
        TAKE_COUNT,
        HALTED
    } parse_state_t;

    typedef struct packed {
        rle_pkg::status_t status;
        logic [31:0]      offset;
        logic [31:0]      stamp_ms;
        logic             port;
        logic [7:0]       addr;
        logic [7:0]       value;
    } event_rec_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [31:0] data;
        bit          typed;
        event_rec_t  want;
    } script_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic                              cfg_we   = 1'b0;
    logic [rle_pkg::CfgIndexWidth-1:0] cfg_addr = '0;
    logic [rle_pkg::CfgDataWidth-1:0]  cfg_data = '0;

    // parser model state
    logic         dev_kind  = 1'b0;
    logic [7:0]   chan_sel  = rle_pkg::ChannelAll;
    logic [31:0]  sync_num  = rle_pkg::NumeratorReset;
    logic [31:0]  sync_den  = rle_pkg::DenomReset;
    logic [31:0]  start_ofs = 32'd0;
    parse_state_t parse_st  = SEEK_CMD;
    logic [31:0]  byte_pos  = 32'd0;
    logic [31:0]  tick_cnt  = 32'd0;
    logic         held_port = 1'b0;
    logic [7:0]   held_addr = 8'h00;
    logic [31:0]  cmd_pos   = 32'd0;
    logic [31:0]  count_acc = 32'd0;
    logic [5:0]   count_shift = 6'd0;

    event_rec_t  pending_events[$];
    logic [7:0]  dump_stream[$];
    script_row_t script_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          tail_mode   = 1'b0;

    register_log_event_extractor #(
        .TIME_WIDTH(TimeWidth)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit note_reg(input logic [7:0] a);
        bit r;
        if (dev_kind)
            r = (a >= 8'h28) && (a <= 8'h37);
        else
            r = (a <= 8'h06) || ((a >= 8'ha0) && (a <= 8'hae) && (a[1:0] != 2'b11));
        return r;
    endfunction

    function automatic bit chan_hit(input logic p, input logic [7:0] a);
        bit         r;
        logic [7:0] lane;
        r = 1'b0;
        if (chan_sel == rle_pkg::ChannelAll)
            r = 1'b1;
        else if (dev_kind)
            r = (chan_sel < 8) && !p && (a == 8'h28 + chan_sel || a == 8'h30 + chan_sel);
        else if (chan_sel < 6)
        begin
            lane = chan_sel % 3;
            r = (p == (chan_sel >= 3)) && (a == 8'ha0 + lane || a == 8'ha4 + lane);
        end
        else if (chan_sel < 9)
        begin
            lane = 8'((chan_sel - 6) * 2);
            r = !p && (a == lane || a == lane + 8'd1);
        end
        return r;
    endfunction

    function automatic logic [31:0] elapsed_ms();
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] prod;
        num  = (sync_num == 0) ? 64'(rle_pkg::NumeratorReset) : 64'(sync_num);
        den  = (sync_den == 0) ? 64'(rle_pkg::DenomReset) : 64'(sync_den);
        prod = 64'(tick_cnt) * num;
        prod = prod * 64'd1000;
        prod = prod / den;
        if (TimeWidth < 64)
            prod = prod & ((64'd1 << TimeWidth) - 64'd1);
        return prod[31:0];
    endfunction

    function automatic bit predict_byte(input logic [7:0] b, output event_rec_t ev);
        bit          hit;
        logic [31:0] pos;
        hit = 1'b0;
        ev  = '0;
        pos = byte_pos;
        if (parse_st != HALTED)
        begin
            byte_pos = pos + 32'd1;
            case (parse_st)
                SEEK_CMD:
                begin
                    if (b == rle_pkg::CmdPort0 || b == rle_pkg::CmdPort1)
                    begin
                        held_port = b[0];
                        cmd_pos   = pos;
                        parse_st  = TAKE_ADDR;
                    end
                    else if (b == rle_pkg::CmdTick)
                        tick_cnt = tick_cnt + 32'd1;
                    else if (b == rle_pkg::CmdWait)
                    begin
                        count_acc   = 32'd0;
                        count_shift = 6'd0;
                        parse_st    = TAKE_COUNT;
                    end
                    else
                    begin
                        ev.status   = (b == rle_pkg::CmdEnd) ? rle_pkg::STATUS_END
                                                             : rle_pkg::STATUS_ERROR;
                        ev.offset   = pos;
                        ev.stamp_ms = elapsed_ms();
                        hit         = 1'b1;
                        parse_st    = HALTED;
                    end
                end
                TAKE_ADDR:
                begin
                    held_addr = b;
                    parse_st  = TAKE_VALUE;
                end
                TAKE_VALUE:
                begin
                    if (note_reg(held_addr) && chan_hit(held_port, held_addr))
                    begin
                        ev.status   = rle_pkg::STATUS_WRITE;
                        ev.offset   = cmd_pos;
                        ev.stamp_ms = elapsed_ms();
                        ev.port     = held_port;
                        ev.addr     = held_addr;
                        ev.value    = b;
                        hit         = 1'b1;
                    end
                    parse_st = SEEK_CMD;
                end
                TAKE_COUNT:
                begin
                    if (count_shift < 32)
                        count_acc = count_acc | 32'(64'(b[6:0]) << count_shift);
                    count_shift = (count_shift + 6'd7 > 6'd35) ? 6'd35 : count_shift + 6'd7;
                    if (!b[7])
                    begin
                        tick_cnt = tick_cnt + count_acc + 32'd2;
                        parse_st = SEEK_CMD;
                    end
                end
                default: parse_st = HALTED;
            endcase
        end
        return hit;
    endfunction

    function automatic void row_byte(input logic [7:0] b);
        script_q.push_back('{1'b0, 3'd0, {24'd0, b}, 1'b0, event_rec_t'('0)});
    endfunction

    function automatic void row_typed(input logic [7:0] b, input event_rec_t ev);
        script_q.push_back('{1'b0, 3'd0, {24'd0, b}, 1'b1, ev});
    endfunction

    function automatic void row_cfg(input logic [2:0] idx, input logic [31:0] v);
        script_q.push_back('{1'b1, idx, v, 1'b0, event_rec_t'('0)});
    endfunction

    function automatic logic [31:0] pick_rate();
        int unsigned r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0: v = 32'd0;
            1: v = 32'd1;
            2: v = 32'hffff_ffff;
            3, 4, 5: v = $urandom_range(1, 100);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void gen_command();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            dump_stream.push_back(8'($urandom_range(0, 1)));
            if (dev_kind)
                dump_stream.push_back(8'h28 + 8'($urandom_range(0, 15)));
            else
            begin
                k = $urandom_range(0, 18);
                if (k < 7)
                    dump_stream.push_back(8'(k));
                else
                    dump_stream.push_back(8'ha0 + 8'(4 * ((k - 7) / 3) + (k - 7) % 3));
            end
            dump_stream.push_back(8'($urandom));
        end
        else if (r < 60)
        begin
            dump_stream.push_back(8'($urandom_range(0, 1)));
            dump_stream.push_back(8'($urandom));
            dump_stream.push_back(8'($urandom));
        end
        else if (r < 75)
            dump_stream.push_back(rle_pkg::CmdTick);
        else if (r < 90)
        begin
            dump_stream.push_back(rle_pkg::CmdWait);
            dump_stream.push_back(8'($urandom_range(0, 127)));
        end
        else
        begin
            dump_stream.push_back(rle_pkg::CmdWait);
            k = $urandom_range(0, 6);
            repeat (k) dump_stream.push_back({1'b1, 7'($urandom)});
            dump_stream.push_back({1'b0, 7'($urandom)});
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input event_rec_t want);
        event_rec_t ev;
        bit         hit;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        hit = predict_byte(b, ev);
        if (typed)
            ev = want;
        if (hit || typed)
            pending_events.push_back(ev);
        if (!tail_mode && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (IdleLatency) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= v;
        @(posedge clk);
        case (idx)
            rle_pkg::CfgDeviceKind:    dev_kind = v[0];
            rle_pkg::CfgChannelSelect: chan_sel = v[7:0];
            rle_pkg::CfgSyncNumerator: sync_num = v;
            rle_pkg::CfgSyncDenom:     sync_den = v;
            rle_pkg::CfgStartOffset:
            begin
                start_ofs = v;
                byte_pos  = v;
            end
            default: ;
        endcase
    endtask

    task automatic shuffle_config();
        int unsigned r;
        logic [31:0] v;
        if ($urandom_range(0, 3) != 0)
            write_reg(rle_pkg::CfgDeviceKind, 32'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                v = 32'(rle_pkg::ChannelAll);
            else if (r < 8)
                v = dev_kind ? $urandom_range(0, 8) : $urandom_range(0, 9);
            else
                v = $urandom_range(0, 254);
            write_reg(rle_pkg::CfgChannelSelect, v);
        end
        if ($urandom_range(0, 3) != 0)
            write_reg(rle_pkg::CfgSyncNumerator, pick_rate());
        if ($urandom_range(0, 3) != 0)
            write_reg(rle_pkg::CfgSyncDenom, pick_rate());
        if ($urandom_range(0, 2) == 0)
        begin
            r = $urandom_range(0, 3);
            if (r == 0)
                v = 32'd0;
            else if (r == 1)
                v = 32'hffff_ffff - $urandom_range(0, 200);
            else
                v = $urandom;
            write_reg(rle_pkg::CfgStartOffset, v);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else if (!tail_mode && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : event_check
        event_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected word: status %0d offset %h", m_tuser, m_tdata[31:0]);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_events.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count = error_count + 1;
                end
                if (m_tdata[31:0] !== want.offset)
                begin
                    $error("event_offset: expected %h, got %h", want.offset, m_tdata[31:0]);
                    error_count = error_count + 1;
                end
                if (m_tdata[63:32] !== want.stamp_ms)
                begin
                    $error("time_ms: expected %h, got %h", want.stamp_ms, m_tdata[63:32]);
                    error_count = error_count + 1;
                end
                if (m_tdata[64] !== want.port)
                begin
                    $error("port: expected %0d, got %0d", want.port, m_tdata[64]);
                    error_count = error_count + 1;
                end
                if (m_tdata[72:65] !== want.addr)
                begin
                    $error("reg_addr: expected %h, got %h", want.addr, m_tdata[72:65]);
                    error_count = error_count + 1;
                end
                if (m_tdata[80:73] !== want.value)
                begin
                    $error("reg_value: expected %h, got %h", want.value, m_tdata[80:73]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        script_row_t row;
        event_rec_t  blank;
        int          rand_sent;
        int          phase_len;
        blank = '0;

        // first words after reset: default timing gives ticks*10 ms
        row_byte(rle_pkg::CmdPort0);
        row_byte(8'h00);
        row_typed(8'hff, '{rle_pkg::STATUS_WRITE, 32'd0, 32'd0, 1'b0, 8'h00, 8'hff});
        row_byte(rle_pkg::CmdTick);
        row_byte(rle_pkg::CmdPort1);
        row_byte(8'hae);
        row_typed(8'h00, '{rle_pkg::STATUS_WRITE, 32'd4, 32'd10, 1'b1, 8'hae, 8'h00});
        row_byte(rle_pkg::CmdWait);
        row_byte(8'h80);
        row_byte(8'h00);
        // OPM table, one channel, then a channel beyond the table
        row_cfg(rle_pkg::CfgDeviceKind, 32'd1);
        row_cfg(rle_pkg::CfgChannelSelect, 32'd3);
        row_byte(rle_pkg::CmdPort0);
        row_byte(8'h2b);
        row_byte(8'h12);
        row_cfg(rle_pkg::CfgChannelSelect, 32'd200);
        row_byte(rle_pkg::CmdPort0);
        row_byte(8'h28);
        row_byte(8'h01);
        // zero timer registers fall back to defaults
        row_cfg(rle_pkg::CfgChannelSelect, 32'(rle_pkg::ChannelAll));
        row_cfg(rle_pkg::CfgSyncNumerator, 32'd0);
        row_cfg(rle_pkg::CfgSyncDenom, 32'd0);
        row_byte(rle_pkg::CmdPort1);
        row_byte(8'h37);
        row_byte(8'h7f);
        // product overflow, long count with saturated shift, offset wrap
        row_cfg(rle_pkg::CfgSyncNumerator, 32'hffff_ffff);
        row_cfg(rle_pkg::CfgSyncDenom, 32'd1);
        row_cfg(rle_pkg::CfgStartOffset, 32'hffff_fffe);
        row_byte(rle_pkg::CmdWait);
        repeat (6) row_byte(8'hff);
        row_byte(8'h7f);
        row_byte(rle_pkg::CmdPort0);
        row_byte(8'h28);
        row_byte(8'hff);
        row_cfg(rle_pkg::CfgDeviceKind, 32'd0);
        row_cfg(rle_pkg::CfgChannelSelect, 32'd8);
        row_cfg(rle_pkg::CfgSyncDenom, 32'hffff_ffff);
        row_byte(rle_pkg::CmdPort0);
        row_byte(8'h05);
        row_byte(8'h80);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < script_q.size(); i++)
        begin
            row = script_q[i];
            if (row.is_cfg)
            begin
                if (i == 0 || !script_q[i-1].is_cfg)
                    wait_idle();
                write_reg(row.idx, row.data);
                if (i + 1 == script_q.size() || !script_q[i+1].is_cfg)
                    cfg_we <= 1'b0;
            end
            else
                send_byte(row.data[7:0], row.typed, row.want);
        end

        // phases may end inside a command, so settings change mid-write too
        rand_sent = 0;
        while (rand_sent < RandomItems)
        begin
            wait_idle();
            shuffle_config();
            phase_len = $urandom_range(40, 160);
            repeat (phase_len)
            begin
                tail_mode = (rand_sent >= RandomItems - TailItems);
                if (dump_stream.size() == 0)
                    gen_command();
                send_byte(dump_stream.pop_front(), 1'b0, blank);
                rand_sent = rand_sent + 1;
            end
        end
        while (dump_stream.size() != 0)
            send_byte(dump_stream.pop_front(), 1'b0, blank);

        if ($urandom_range(0, 1) == 0)
            send_byte(rle_pkg::CmdEnd, 1'b0, blank);
        else
            send_byte(8'($urandom_range(2, 8'hfc)), 1'b0, blank);
        // halted: everything else is dropped
        repeat (8) send_byte(8'($urandom), 1'b0, blank);
        s_tvalid <= 1'b0;

        while (pending_events.size() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/rle_pkg.sv
rtl/rle_parser.sv
rtl/rle_time.sv
rtl/register_log_event_extractor.sv
test/tb.sv
